FILE: rtl/gtg_pkg.sv
// Shared constants, types and the arctangent table of the go-to-goal controller.
package gtg_pkg;
	localparam int FRAC_BITS     = 11;
	localparam int CORDIC_STAGES = 16;
	localparam int PRESCALE      = 16;
	localparam int POS_W         = 16;
	localparam int HD_W          = 14;
	localparam int SPD_W         = 15;
	localparam int DW            = POS_W + 1;
	localparam int SQ_W          = 2 * DW;
	localparam int SQRT_STEPS    = SQ_W / 2;
	localparam int NSTG          = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
	localparam int CW            = DW + PRESCALE + 3;
	localparam int ZW            = 35;
	localparam int REM_W         = SQRT_STEPS + 3;
	localparam int ZQ_W          = ZW - (30 - FRAC_BITS);
	localparam int ERR_W         = ZQ_W + 1;
	localparam int IDX_W         = 5;
	localparam int THR           = ((1 << FRAC_BITS) + 5) / 10;
	localparam longint THR_SQ    = longint'(THR) * longint'(THR);
	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

	localparam logic [1:0] REG_TARGET_X  = 2'd0;
	localparam logic [1:0] REG_TARGET_Y  = 2'd1;
	localparam logic [1:0] REG_GAIN      = 2'd2;
	localparam logic [1:0] REG_MAX_SPEED = 2'd3;

	typedef struct packed {
		logic signed [POS_W-1:0] target_x;
		logic signed [POS_W-1:0] target_y;
		logic [SPD_W-1:0]        gain;
		logic [SPD_W-1:0]        max_speed;
	} cfg_t;

	typedef struct packed {
		logic signed [CW-1:0]  x;
		logic signed [CW-1:0]  y;
		logic signed [ZW-1:0]  z;
		logic [REM_W-1:0]      rem;
		logic [SQRT_STEPS-1:0] root;
		logic [SQ_W-1:0]       nsh;
		logic                  near;
		logic signed [HD_W-1:0] hd;
	} stage_t;

	// atan(2^-i) in Q2.30
	function automatic logic signed [ZW-1:0] atan_q30(input logic [IDX_W-1:0] i);
		logic signed [ZW-1:0] r;
		unique case (i)
			5'd0:  r = 35'sd843314857;
			5'd1:  r = 35'sd497837830;
			5'd2:  r = 35'sd263043837;
			5'd3:  r = 35'sd133525159;
			5'd4:  r = 35'sd67021687;
			5'd5:  r = 35'sd33543516;
			5'd6:  r = 35'sd16775851;
			5'd7:  r = 35'sd8388437;
			5'd8:  r = 35'sd4194283;
			5'd9:  r = 35'sd2097149;
			5'd10: r = 35'sd1048576;
			5'd11: r = 35'sd524288;
			5'd12: r = 35'sd262144;
			5'd13: r = 35'sd131072;
			5'd14: r = 35'sd65536;
			5'd15: r = 35'sd32768;
			5'd16: r = 35'sd16384;
			5'd17: r = 35'sd8192;
			5'd18: r = 35'sd4096;
			5'd19: r = 35'sd2048;
			5'd20: r = 35'sd1024;
			5'd21: r = 35'sd512;
			5'd22: r = 35'sd256;
			default: r = 35'sd128;
		endcase
		return r;
	endfunction
endpackage

FILE: rtl/go_to_goal_p_controller.sv
// Throughput: one word per cycle while the output is not stalled; two front stages,
// 17 middle stages (one square-root digit each, a CORDIC iteration in the first 16)
// and three back stages, all stalled together.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset: asynchronous, active low; clears all valid bits and loads the register
// defaults (target 2.0, 2.0; gain 1.0; max speed 3.0).
module go_to_goal_p_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pos_x[15:0], pos_y[31:16], heading[45:32], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // linear_speed[14:0], angular_speed[29:15], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	gtg_pkg::cfg_t   cfg_q;
	logic            en;
	logic            v [gtg_pkg::NSTG+1];
	gtg_pkg::stage_t d [gtg_pkg::NSTG+1];
	logic [gtg_pkg::SPD_W-1:0] lin, ang;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x  <= gtg_pkg::POS_W'(2 << gtg_pkg::FRAC_BITS);
			cfg_q.target_y  <= gtg_pkg::POS_W'(2 << gtg_pkg::FRAC_BITS);
			cfg_q.gain      <= gtg_pkg::SPD_W'(1 << gtg_pkg::FRAC_BITS);
			cfg_q.max_speed <= gtg_pkg::SPD_W'(3 << gtg_pkg::FRAC_BITS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gtg_pkg::REG_TARGET_X:  cfg_q.target_x  <= cfg_data;
				gtg_pkg::REG_TARGET_Y:  cfg_q.target_y  <= cfg_data;
				gtg_pkg::REG_GAIN:      cfg_q.gain      <= cfg_data[gtg_pkg::SPD_W-1:0];
				gtg_pkg::REG_MAX_SPEED: cfg_q.max_speed <= cfg_data[gtg_pkg::SPD_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	gtg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.pos_x     (s_tdata[15:0]),
		.pos_y     (s_tdata[31:16]),
		.heading   (s_tdata[45:32]),
		.cfg       (cfg_q),
		.out_valid (v[0]),
		.out_d     (d[0])
	);

	for (genvar k = 0; k < gtg_pkg::NSTG; k++) begin : g_stage
		gtg_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.idx       (gtg_pkg::IDX_W'(k)),
			.do_cordic (k < gtg_pkg::CORDIC_STAGES),
			.do_sqrt   (k < gtg_pkg::SQRT_STEPS),
			.in_valid  (v[k]),
			.in_d      (d[k]),
			.out_valid (v[k+1]),
			.out_d     (d[k+1])
		);
	end

	gtg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (v[gtg_pkg::NSTG]),
		.in_d          (d[gtg_pkg::NSTG]),
		.cfg           (cfg_q),
		.out_valid     (m_tvalid),
		.linear_speed  (lin),
		.angular_speed (ang)
	);

	assign m_tdata = {2'b00, ang, lin};
endmodule

FILE: rtl/gtg_front.sv
// Front end: offset to goal, squared distance, near test and CORDIC prerotation.
module gtg_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic signed [gtg_pkg::POS_W-1:0]        pos_x,
	input  logic signed [gtg_pkg::POS_W-1:0]        pos_y,
	input  logic signed [gtg_pkg::HD_W-1:0]         heading,
	input  gtg_pkg::cfg_t                           cfg,
	output logic                                    out_valid,
	output gtg_pkg::stage_t                         out_d
);
	logic                              valid_s1;
	logic signed [gtg_pkg::DW-1:0]     dx_s1, dy_s1;
	logic signed [gtg_pkg::HD_W-1:0]   hd_s1;
	logic signed [gtg_pkg::SQ_W-1:0]   dx2, dy2;
	logic [gtg_pkg::SQ_W-1:0]          sq;
	logic signed [gtg_pkg::CW-1:0]     x0, y0;
	gtg_pkg::stage_t                   d_s2;
	logic                              valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {cfg.target_x[gtg_pkg::POS_W-1], cfg.target_x}
				- {pos_x[gtg_pkg::POS_W-1], pos_x};
			dy_s1 <= {cfg.target_y[gtg_pkg::POS_W-1], cfg.target_y}
				- {pos_y[gtg_pkg::POS_W-1], pos_y};
			hd_s1 <= heading;
		end
	end

	always_comb begin
		dx2 = dx_s1 * dx_s1;
		dy2 = dy_s1 * dy_s1;
		sq  = gtg_pkg::SQ_W'(dx2) + gtg_pkg::SQ_W'(dy2);
		x0  = gtg_pkg::CW'(dx_s1) <<< gtg_pkg::PRESCALE;
		y0  = gtg_pkg::CW'(dy_s1) <<< gtg_pkg::PRESCALE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2.rem  <= '0;
			d_s2.root <= '0;
			d_s2.nsh  <= sq;
			d_s2.near <= ({30'd0, sq} <= 64'(gtg_pkg::THR_SQ));
			d_s2.hd   <= hd_s1;
			if (dx_s1 < 0) begin
				d_s2.x <= -x0;
				d_s2.y <= -y0;
				d_s2.z <= (dy_s1 >= 0) ? gtg_pkg::PI_Q30 : -gtg_pkg::PI_Q30;
			end else begin
				d_s2.x <= x0;
				d_s2.y <= y0;
				d_s2.z <= '0;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_d     = d_s2;
endmodule

FILE: rtl/gtg_stage.sv
// Middle stage: CORDIC vectoring if do_cordic, one square-root digit if do_sqrt.
module gtg_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [gtg_pkg::IDX_W-1:0]      idx,
	input  logic                           do_cordic,
	input  logic                           do_sqrt,
	input  logic                           in_valid,
	input  gtg_pkg::stage_t                in_d,
	output logic                           out_valid,
	output gtg_pkg::stage_t                out_d
);
	gtg_pkg::stage_t                 nx;
	logic signed [gtg_pkg::CW-1:0]   xs, ys;
	logic [gtg_pkg::REM_W-1:0]       rem_n, trial;
	logic                            valid_q;
	gtg_pkg::stage_t                 d_q;

	always_comb begin
		nx    = in_d;
		xs    = in_d.x >>> idx;
		ys    = in_d.y >>> idx;
		rem_n = {in_d.rem[gtg_pkg::REM_W-3:0], in_d.nsh[gtg_pkg::SQ_W-1 -: 2]};
		trial = gtg_pkg::REM_W'({in_d.root, 2'b01});
		if (do_cordic) begin
			if (in_d.y > 0) begin
				nx.x = in_d.x + ys;
				nx.y = in_d.y - xs;
				nx.z = in_d.z + gtg_pkg::atan_q30(idx);
			end else begin
				nx.x = in_d.x - ys;
				nx.y = in_d.y + xs;
				nx.z = in_d.z - gtg_pkg::atan_q30(idx);
			end
		end
		if (do_sqrt) begin
			nx.nsh = in_d.nsh << 2;
			if (rem_n >= trial) begin
				nx.rem  = rem_n - trial;
				nx.root = {in_d.root[gtg_pkg::SQRT_STEPS-2:0], 1'b1};
			end else begin
				nx.rem  = rem_n;
				nx.root = {in_d.root[gtg_pkg::SQRT_STEPS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nx;
		end
	end

	assign out_valid = valid_q;
	assign out_d     = d_q;
endmodule

FILE: rtl/gtg_back.sv
// Back end: angle rounding, heading error, gain multiply, mode select and clamped speeds.
module gtg_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  gtg_pkg::stage_t               in_d,
	input  gtg_pkg::cfg_t                 cfg,
	output logic                          out_valid,
	output logic [gtg_pkg::SPD_W-1:0]     linear_speed,
	output logic [gtg_pkg::SPD_W-1:0]     angular_speed
);
	logic signed [gtg_pkg::ZW-1:0]    zr;
	logic signed [gtg_pkg::ZQ_W-1:0]  zq;
	logic signed [gtg_pkg::ERR_W-1:0] err;
	logic [gtg_pkg::ERR_W-1:0]        aerr;

	logic                             valid_s1, valid_s2, valid_s3;
	logic [gtg_pkg::ERR_W-1:0]        aerr_s1, aerr_s2;
	logic [gtg_pkg::SQRT_STEPS-1:0]   dist_s1;
	logic                             near_s1, near_s2;
	logic [31:0]                      prod_s2;
	logic [gtg_pkg::SQ_W-gtg_pkg::FRAC_BITS-1:0] lin_raw;
	logic [gtg_pkg::SPD_W-1:0]        lin_s3, ang_s3;

	always_comb begin
		zr   = (in_d.z + (gtg_pkg::ZW'(1) <<< (29 - gtg_pkg::FRAC_BITS)))
			>>> (30 - gtg_pkg::FRAC_BITS);
		zq   = zr[gtg_pkg::ZQ_W-1:0];
		err  = {zq[gtg_pkg::ZQ_W-1], zq}
			- gtg_pkg::ERR_W'(in_d.hd);
		aerr = (err < 0) ? gtg_pkg::ERR_W'(-err) : gtg_pkg::ERR_W'(err);
		lin_raw = (gtg_pkg::SQ_W-gtg_pkg::FRAC_BITS)'(prod_s2 >> gtg_pkg::FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aerr_s1 <= aerr;
			dist_s1 <= in_d.root;
			near_s1 <= in_d.near;
			prod_s2 <= 32'(cfg.gain) * 32'(dist_s1);
			aerr_s2 <= aerr_s1;
			near_s2 <= near_s1;
			lin_s3  <= '0;
			ang_s3  <= '0;
			if (!near_s2) begin
				if (aerr_s2 > gtg_pkg::ERR_W'(gtg_pkg::THR)) begin
					ang_s3 <= aerr_s2[gtg_pkg::ERR_W-1] ? '1
						: aerr_s2[gtg_pkg::SPD_W-1:0];
				end else if (lin_raw > gtg_pkg::SQ_W'(cfg.max_speed)) begin
					lin_s3 <= cfg.max_speed;
				end else begin
					lin_s3 <= lin_raw[gtg_pkg::SPD_W-1:0];
				end
			end
		end
	end

	assign out_valid     = valid_s3;
	assign linear_speed  = lin_s3;
	assign angular_speed = ang_s3;

`ifndef NO_ASSERTIONS
	a_one_drive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (lin_s3 != '0) |-> (ang_s3 == '0))
		else $error("both drives nonzero");
	a_lin_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (lin_s3 <= cfg.max_speed))
		else $error("linear speed above clamp");
	a_turn_thr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (ang_s3 != '0) |-> (ang_s3 > gtg_pkg::SPD_W'(gtg_pkg::THR)))
		else $error("turn rate below threshold");
`endif
endmodule

FILE: tb/tb_go_to_goal_p_controller.sv
// Self-checking testbench for the go-to-goal controller: directed table plus random poses.
`timescale 1ns / 100ps

module tb_go_to_goal_p_controller;

	typedef struct {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [13:0] hd;
		bit                 known;   // expected command typed in
		logic [14:0]        lin;
		logic [14:0]        ang;
	} pose_row_t;

	// same layout as m_tdata[29:0]
	typedef struct packed {
		logic [14:0] ang;
		logic [14:0] lin;
	} cmd_t;

	localparam longint ATAN_TAB[24] = '{
		843314857, 497837830, 263043837, 133525159, 67021687, 33543516, 16775851,
		8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048, 1024, 512, 256, 128};
	localparam longint PI_Z   = 64'sd3373259426;
	localparam int     NEAR_Q = 205;
	localparam int     LIMIT  = 400000;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready;
	logic [47:0] s_tdata;
	logic [31:0] m_tdata;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	go_to_goal_p_controller u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// controller settings as the predictor sees them
	longint goal_x, goal_y, kp, vmax;
	cmd_t   cmd_q[$];
	int     errors;
	int     src_idle, snk_idle;   // idle percentages
	bit     hold_sink;
	int     hold_cycles;
	longint cyc;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint heading_target(longint dy, longint dx);
		longint x, y, z, xs, ys;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		x = dx <<< 16;
		y = dy <<< 16;
		if (x < 0) begin
			z = (y >= 0) ? PI_Z : -PI_Z;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < gtg_pkg::CORDIC_STAGES; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_TAB[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_TAB[i];
			end
		end
		return shr_floor(z + (64'sd1 <<< 18), 19);
	endfunction

	function automatic longint root_floor(longint n);
		longint r;
		r = 0;
		for (int b = 20; b >= 0; b--)
			if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= n)
				r += 64'sd1 <<< b;
		return r;
	endfunction

	function automatic cmd_t drive_command(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [13:0] hd);
		longint dx, dy, sq, err, lin, ang;
		cmd_t c;
		dx = goal_x - longint'(px);
		dy = goal_y - longint'(py);
		sq = dx * dx + dy * dy;
		lin = 0;
		ang = 0;
		if (sq > NEAR_Q * NEAR_Q) begin
			err = heading_target(dy, dx) - longint'(hd);
			if (err < 0)
				err = -err;
			if (err > NEAR_Q)
				ang = (err > 32767) ? 32767 : err;
			else
				lin = (kp * root_floor(sq)) >>> gtg_pkg::FRAC_BITS;
		end
		if (lin > vmax)
			lin = vmax;
		if (lin > 32767)
			lin = 32767;
		c.lin = lin[14:0];
		c.ang = ang[14:0];
		return c;
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (cmd_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			gtg_pkg::REG_TARGET_X:  goal_x = longint'(signed'(val));
			gtg_pkg::REG_TARGET_Y:  goal_y = longint'(signed'(val));
			gtg_pkg::REG_GAIN:      kp = val[14:0];
			gtg_pkg::REG_MAX_SPEED: vmax = val[14:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// tvalid stays up between back-to-back words; it drops only for idle cycles
	task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [13:0] hd);
		if ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, hd, py, px};
		do @(posedge clk); while (!s_tready);
		cmd_q.push_back(drive_command(px, py, hd));
	endtask

	task automatic random_poses(int n);
		logic signed [15:0] px, py;
		logic signed [13:0] hd;
		int mode;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(9);
			hd = $urandom_range(12868) - 6434;
			if (mode < 3) begin
				// near the goal, hits the stop window and its edge
				px = goal_x + $urandom_range(500) - 250;
				py = goal_y + $urandom_range(500) - 250;
			end else begin
				px = $urandom;
				py = $urandom;
				if (mode < 7) begin
					// aim heading at the goal so the drive branch is taken
					hd = heading_target(goal_y - py, goal_x - px) + $urandom_range(400) - 200;
				end else if (mode == 9)
					hd = $urandom;
			end
			send_pose(px, py, hd);
		end
	endtask

	// sink side and checker
	always @(posedge clk) begin
		cmd_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[29:0];
				if (cmd_q.size() == 0) begin
					$display("%0t unexpected word: expected none, actual %h", $time, m_tdata);
					errors++;
				end else begin
					want = cmd_q.pop_front();
					if (got.lin !== want.lin) begin
						$display("%0t linear_speed: expected %0d, actual %0d",
							$time, want.lin, got.lin);
						errors++;
					end
					if (got.ang !== want.ang) begin
						$display("%0t angular_speed: expected %0d, actual %0d",
							$time, want.ang, got.ang);
						errors++;
					end
				end
			end
			if (hold_sink)
				m_tready <= 1'b0;
			else
				m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			hold_sink <= (hold_cycles > 1);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == LIMIT) begin
			$display("[go_to_goal_p_controller] ERROR");
			$finish;
		end
	end

	pose_row_t plan[$];

	initial begin
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		cfg_valid = 1'b0; cfg_index = gtg_pkg::REG_TARGET_X; cfg_data = '0;
		hold_sink = 1'b0; hold_cycles = 0; cyc = 0; errors = 0;
		goal_x = 4096; goal_y = 4096; kp = 2048; vmax = 6144;
		src_idle = 19; snk_idle = 68;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows against reset settings
		plan = '{
			'{16'sd4096, 16'sd4096, 14'sd0, 1'b1, 15'd0, 15'd0},     // at goal
			'{16'sd4096, 16'sd3891, 14'sd0, 1'b1, 15'd0, 15'd0},     // stop edge
			'{16'sd0, 16'sd4096, 14'sd0, 1'b1, 15'd4096, 15'd0},     // drive, aligned
			'{16'sd0, 16'sd0, 14'sd1608, 1'b0, 15'd0, 15'd0},
			'{16'sd0, 16'sd0, 14'sd0, 1'b0, 15'd0, 15'd0},           // turn
			'{16'sh8000, 16'sh8000, 14'sd6434, 1'b0, 15'd0, 15'd0},
			'{16'sh7fff, 16'sh7fff, -14'sd6434, 1'b0, 15'd0, 15'd0},
			'{16'sh7fff, 16'sd4096, 14'sh1fff, 1'b0, 15'd0, 15'd0},  // heading past pi
			'{16'sh7fff, 16'sd4096, 14'sh2000, 1'b0, 15'd0, 15'd0},
			'{16'sd8192, 16'sd5000, 14'sd0, 1'b0, 15'd0, 15'd0},
			'{16'sd4096, 16'sd0, 14'sd3217, 1'b0, 15'd0, 15'd0},
			'{16'sd4096, 16'sh8000, 14'sd3217, 1'b0, 15'd0, 15'd0}
		};
		foreach (plan[i]) begin
			send_pose(plan[i].px, plan[i].py, plan[i].hd);
			if (plan[i].known && (cmd_q[$].lin !== plan[i].lin || cmd_q[$].ang !== plan[i].ang)) begin
				$display("%0t table row %0d: expected %0d/%0d, predicted %0d/%0d", $time, i,
					plan[i].lin, plan[i].ang, cmd_q[$].lin, cmd_q[$].ang);
				errors++;
			end
		end
		wait_drained();

		random_poses(400);
		wait_drained();

		// extreme settings: far corner goal, top gain, no clamp headroom
		write_reg(gtg_pkg::REG_TARGET_X, 16'h8000);
		write_reg(gtg_pkg::REG_TARGET_Y, 16'h7fff);
		write_reg(gtg_pkg::REG_GAIN, 16'h7fff);
		write_reg(gtg_pkg::REG_MAX_SPEED, 16'h7fff);
		src_idle = 68; snk_idle = 19;
		random_poses(350);

		// long sink stall so the pipeline backs up
		hold_sink <= 1'b1;
		hold_cycles <= 200;
		random_poses(60);
		wait_drained();

		write_reg(gtg_pkg::REG_TARGET_X, 16'h7fff);
		write_reg(gtg_pkg::REG_TARGET_Y, 16'h8000);
		write_reg(gtg_pkg::REG_GAIN, 16'h0000);
		write_reg(gtg_pkg::REG_MAX_SPEED, 16'h0000);
		random_poses(150);
		wait_drained();

		src_idle = 0; snk_idle = 0;
		write_reg(gtg_pkg::REG_TARGET_X, 16'($urandom));
		write_reg(gtg_pkg::REG_TARGET_Y, 16'($urandom));
		write_reg(gtg_pkg::REG_GAIN, 16'($urandom_range(8192)));
		write_reg(gtg_pkg::REG_MAX_SPEED, 16'($urandom_range(16384)));
		random_poses(380);
		wait_drained();

		if (errors == 0)
			$display("[go_to_goal_p_controller] OK");
		else
			$display("[go_to_goal_p_controller] ERROR");
		$finish;
	end
endmodule
